FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; empty bodies under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("never failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

FILE: rtl/kuz_pkg.sv
// Kuznyechik package: payload types, S-box tables, GF(2^8) helpers.
// No dependencies.
package kuz_pkg;
    localparam int ROUND_KEY_COUNT = 10;
    localparam int KEY_WORDS = 4;
    localparam logic [1:0] CFG_KEY0 = 2'd0;

    typedef struct packed {
        logic        func;
        logic [63:0] block_hi;
        logic [63:0] block_lo;
    } kuz_in_t;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } kuz_out_t;

    typedef struct packed {
        logic         start;
        logic         inverse;
        logic [127:0] din;
    } kuz_lin_req_t;

    localparam logic [7:0] SBOX [256] = '{
        8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
        8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
        8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
        8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
        8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
        8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
        8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
        8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
        8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
        8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
        8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
        8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
        8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
        8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
        8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
        8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
    };

    localparam logic [7:0] LCOEF [16] = '{
        8'd148,8'd32,8'd133,8'd16,8'd194,8'd192,8'd1,8'd251,
        8'd1,8'd192,8'd194,8'd16,8'd133,8'd32,8'd148,8'd1
    };

    function automatic logic [7:0] sbox_inv(input logic [7:0] v);
        logic [7:0] r;
        r = 8'd0;
        for (int i = 0; i < 256; i++)
        begin
            if (SBOX[i] == v)
            begin
                r = 8'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] acc;
        x = {1'b0, a};
        acc = 8'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ x[7:0];
            end
            x = {x[7:0], 1'b0};
            if (x[8])
            begin
                x = x ^ 9'h1C3;
            end
        end
        return acc;
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] v, input logic inv);
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
        begin
            r[i*8 +: 8] = inv ? sbox_inv(v[i*8 +: 8]) : SBOX[v[i*8 +: 8]];
        end
        return r;
    endfunction
endpackage

FILE: rtl/kuz_lin.sv
// Kuznyechik linear layer: one LFSR step per cycle, 16 steps per call.
// Depends on kuz_pkg.
module kuz_lin
    import kuz_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  kuz_lin_req_t req,
    output logic         done,
    output logic [127:0] dout
);
    logic [127:0] data_reg, data_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         inv_reg, inv_next;
    logic         done_reg, done_next;
    logic [127:0] rot;
    logic [7:0]   t;

    // byte 0 is bits [127:120]
    always_comb
    begin
        rot = inv_reg ? {data_reg[119:0], data_reg[127:120]} : data_reg;
        t = 8'd0;
        for (int i = 0; i < 16; i++)
        begin
            t = t ^ gf_mul(rot[127 - 8*i -: 8], LCOEF[i]);
        end
    end

    always_comb
    begin
        data_next = data_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        inv_next = inv_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            data_next = req.din;
            inv_next = req.inverse;
            cnt_next = 4'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            data_next = inv_reg ? {rot[127:8], t} : {t, data_reg[127:8]};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 4'd0;
            inv_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
            inv_reg <= inv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign done = done_reg;
    assign dout = data_reg;
endmodule

FILE: rtl/kuznyechik_block_cipher_top.sv
// Kuznyechik block cipher top: sequencer, key schedule, round key store.
// Depends on kuz_pkg, kuz_lin and assert_macros.svh.
//
// Usage: write key words with cfg_we/cfg_index/cfg_data while idle.
// Requests enter on in_valid/in_ready with a kuz_in_t payload (func 0
// encrypts, 1 decrypts); results leave on out_valid/out_ready as kuz_out_t.
// One request at a time: in_ready is low from acceptance until the sequencer
// is back in idle. Each of the nine full rounds runs the shared linear unit
// (start in ST_RND, wait for done in ST_RNDW); a final round only XORs the
// last round key. The next request can be taken in the same cycle that the
// result becomes valid.
// The first request after reset or after a key write first expands
// the keys: 32 Feistel steps through the same unit, each of which also
// runs the unit once to form its round constant.
// The result register holds while the receiver stalls; a following request
// is taken but holds in its last round until the waiting result drains.
// Reset clears the keys to zero and marks the round keys stale.
`include "assert_macros.svh"
module kuznyechik_block_cipher_top
    import kuz_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  kuz_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output kuz_out_t    out_data
);
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_KCON   = 4'd1;
    localparam logic [3:0] ST_KCONW  = 4'd2;
    localparam logic [3:0] ST_KF     = 4'd3;
    localparam logic [3:0] ST_KFW    = 4'd4;
    localparam logic [3:0] ST_RND    = 4'd5;
    localparam logic [3:0] ST_RNDW   = 4'd6;
    localparam logic [3:0] ST_OUT    = 4'd7;

    logic [3:0]   state_reg, state_next;
    logic [63:0]  key_reg [KEY_WORDS];
    logic [127:0] rk_reg [ROUND_KEY_COUNT];
    logic         ready_keys_reg;
    logic [127:0] a1_reg, a1_next, a0_reg, a0_next, cst_reg, cst_next;
    logic [127:0] blk_reg, blk_next;
    logic [4:0]   step_reg, step_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic         func_reg, func_next;
    logic         rk_we;
    logic [3:0]   rk_idx;
    logic [127:0] rk_a, rk_b;
    kuz_lin_req_t lreq;
    logic         ldone;
    logic [127:0] lout;
    logic         out_valid_reg, out_valid_next;
    logic [127:0] res_reg, res_next;
    logic [7:0]   cnum;
    logic         out_free;

    kuz_lin u_lin (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (lreq),
        .done (ldone),
        .dout (lout)
    );

    assign cnum = {3'd0, step_reg} + 8'd1;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        a1_next = a1_reg;
        a0_next = a0_reg;
        cst_next = cst_reg;
        blk_next = blk_reg;
        step_next = step_reg;
        rnd_next = rnd_reg;
        func_next = func_reg;
        out_valid_next = out_valid_reg;
        res_next = res_reg;
        lreq = '{start: 1'b0, inverse: 1'b0, din: 128'd0};
        rk_we = 1'b0;
        rk_idx = 4'd0;
        rk_a = a1_reg;
        rk_b = a0_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = in_data.func;
                    blk_next = {in_data.block_hi, in_data.block_lo};
                    if (!ready_keys_reg)
                    begin
                        a1_next = {key_reg[0], key_reg[1]};
                        a0_next = {key_reg[2], key_reg[3]};
                        step_next = 5'd0;
                        rk_we = 1'b1;
                        rk_idx = 4'd0;
                        rk_a = {key_reg[0], key_reg[1]};
                        rk_b = {key_reg[2], key_reg[3]};
                        state_next = ST_KCON;
                    end
                    else
                    begin
                        state_next = ST_RND;
                        rnd_next = in_data.func ? 4'd9 : 4'd0;
                    end
                end
            end
            ST_KCON:
            begin
                lreq = '{start: 1'b1, inverse: 1'b0, din: {120'd0, cnum}};
                state_next = ST_KCONW;
            end
            ST_KCONW:
            begin
                if (ldone)
                begin
                    cst_next = lout;
                    state_next = ST_KF;
                end
            end
            ST_KF:
            begin
                lreq = '{start: 1'b1, inverse: 1'b0, din: sub_bytes(a1_reg ^ cst_reg, 1'b0)};
                state_next = ST_KFW;
            end
            ST_KFW:
            begin
                if (ldone)
                begin
                    a1_next = lout ^ a0_reg;
                    a0_next = a1_reg;
                    step_next = step_reg + 5'd1;
                    state_next = ST_KCON;
                    if (step_reg[2:0] == 3'd7)
                    begin
                        rk_we = 1'b1;
                        rk_idx = {2'd0, step_reg[4:3]} + 4'd1;
                        rk_a = lout ^ a0_reg;
                        rk_b = a1_reg;
                        if (step_reg == 5'd31)
                        begin
                            state_next = ST_RND;
                            rnd_next = func_reg ? 4'd9 : 4'd0;
                        end
                    end
                end
            end
            ST_RND:
            begin
                if (!func_reg)
                begin
                    if (rnd_reg == 4'd9)
                    begin
                        if (out_free)
                        begin
                            res_next = blk_reg ^ rk_reg[9];
                            out_valid_next = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        lreq = '{start: 1'b1, inverse: 1'b0,
                                 din: sub_bytes(blk_reg ^ rk_reg[rnd_reg], 1'b0)};
                        state_next = ST_RNDW;
                    end
                end
                else
                begin
                    if (rnd_reg == 4'd0)
                    begin
                        if (out_free)
                        begin
                            res_next = blk_reg ^ rk_reg[0];
                            out_valid_next = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        lreq = '{start: 1'b1, inverse: 1'b1,
                                 din: blk_reg ^ rk_reg[rnd_reg]};
                        state_next = ST_RNDW;
                    end
                end
            end
            ST_RNDW:
            begin
                if (ldone)
                begin
                    blk_next = func_reg ? sub_bytes(lout, 1'b1) : lout;
                    rnd_next = func_reg ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
                    state_next = ST_RND;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_keys_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg <= 5'd0;
            rnd_reg <= 4'd0;
            func_reg <= 1'b0;
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                key_reg[i] <= 64'd0;
            end
            for (int i = 0; i < ROUND_KEY_COUNT; i++)
            begin
                rk_reg[i] <= 128'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg <= step_next;
            rnd_reg <= rnd_next;
            func_reg <= func_next;
            if (state_reg == ST_KFW && state_next == ST_RND)
            begin
                ready_keys_reg <= 1'b1;
            end
            if (cfg_we)
            begin
                key_reg[cfg_index] <= cfg_data;
                ready_keys_reg <= 1'b0;
            end
            if (rk_we)
            begin
                rk_reg[{rk_idx[2:0], 1'b0}] <= rk_a;
                rk_reg[{rk_idx[2:0], 1'b0} + 4'd1] <= rk_b;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg <= a1_next;
        a0_reg <= a0_next;
        cst_reg <= cst_next;
        blk_reg <= blk_next;
        res_reg <= res_next;
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = '{result_hi: res_reg[127:64], result_lo: res_reg[63:0]};

    `ASSERT_NEVER(a_no_accept_busy, clk, rst_n, in_valid && in_ready && state_reg != ST_IDLE)
    `ASSERT_IMPL(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))
    `ASSERT_NEVER(a_rnd_range, clk, rst_n, rnd_reg > 4'd9)
endmodule
